@@ sv/stst_pkg.sv @@
// Shared types, codes and constants of the section timing statistics table.
package stst_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int KEY_PORT_BITS  = 32;
    localparam int TS_BITS        = 63;
    localparam int TIME_BITS      = 64;
    localparam int COUNT_BITS     = 32;
    localparam int STATUS_BITS    = 3;
    localparam int SLOT_OUT_BITS  = 6;

    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_END   = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BEGIN_RUNNING = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_END_NO_SLOT   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_END_IDLE      = 3'd4;

    localparam logic [TS_BITS-1:0]    TOTAL_MAX = {TS_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [TS_BITS-1:0]    start;
        logic [TS_BITS-1:0]    total;
        logic [TIME_BITS-1:0]  min;
        logic [TIME_BITS-1:0]  max;
        logic [COUNT_BITS-1:0] count;
    } stat_rec_t;

    localparam stat_rec_t STAT_RESET = '{
        start: '0,
        total: '0,
        min:   '1,
        max:   '0,
        count: '0
    };

    typedef struct packed {
        logic en;
        logic claim;
        logic running;
    } cam_upd_t;

endpackage

@@ sv/section_timing_stats_table_core.sv @@
// Top level of the section timing statistics table.
//
// Input channel (in_valid/in_ready) carries one event item: action (begin or
// end), section_key and timestamp. Output channel (out_valid/out_ready)
// returns one result item per event: status, slot_index, elapsed_ticks and
// the slot's total, min, max and call count after the update.
// An item passes these steps in order: key compare against the register key
// array at accept, slot encode and statistics memory read, elapsed subtract,
// then the update that writes the memory and loads the output register. The
// next item is accepted only once the previous one has left its update step,
// so the statistics memory read-modify-write never overlaps between items.
// Reset clears all used and running flags; statistics are initialized when
// a slot is first claimed, so no clearing pass runs after reset.
// A result waits in the output register while out_ready is low; the next
// item is still accepted and held at its final update step until the
// output register frees.
module section_timing_stats_table_core #(
    parameter int SLOT_COUNT = stst_pkg::SLOT_COUNT_DEF,
    parameter int KEY_BITS   = stst_pkg::KEY_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic [stst_pkg::KEY_PORT_BITS-1:0]    section_key,
    input  logic [stst_pkg::TS_BITS-1:0]          timestamp,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [stst_pkg::STATUS_BITS-1:0]      status,
    output logic [stst_pkg::SLOT_OUT_BITS-1:0]    slot_index,
    output logic signed [stst_pkg::TIME_BITS-1:0] elapsed_ticks,
    output logic [stst_pkg::TS_BITS-1:0]          total_ticks,
    output logic signed [stst_pkg::TIME_BITS-1:0] min_ticks,
    output logic signed [stst_pkg::TIME_BITS-1:0] max_ticks,
    output logic [stst_pkg::COUNT_BITS-1:0]       call_count
);

    localparam int KEY_W = (KEY_BITS < stst_pkg::KEY_PORT_BITS) ? KEY_BITS
                                                               : stst_pkg::KEY_PORT_BITS;
    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int REC_W = $bits(stst_pkg::stat_rec_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DIFF,
        S_UPDATE
    } state_t;

    state_t                           state_reg, state_next;
    logic                             action_reg, action_next;
    logic [KEY_W-1:0]                 key_reg, key_next;
    logic [stst_pkg::TS_BITS-1:0]     ts_reg, ts_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic                             found_reg, found_next;
    logic                             fresh_reg, fresh_next;
    logic [stst_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [stst_pkg::TIME_BITS-1:0]   elapsed_reg, elapsed_next;

    logic                               out_valid_reg, out_valid_next;
    logic [stst_pkg::STATUS_BITS-1:0]   out_status_reg, out_status_next;
    logic [stst_pkg::SLOT_OUT_BITS-1:0] out_slot_reg, out_slot_next;
    logic [stst_pkg::TIME_BITS-1:0]     out_elapsed_reg, out_elapsed_next;
    stst_pkg::stat_rec_t                out_rec_reg, out_rec_next;

    logic                hit, hit_running, free_any;
    logic [IDX_W-1:0]    hit_idx, free_idx;
    stst_pkg::cam_upd_t  cam_upd;
    logic [REC_W-1:0]    rd_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    stst_pkg::stat_rec_t old_rec, alu_rec, wr_rec;
    logic                upd_fire;
    logic                accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign upd_fire = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    stst_cam #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_W      (KEY_W),
        .IDX_W      (IDX_W)
    ) u_cam (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_en   (accept),
        .lookup_key  (section_key[KEY_W-1:0]),
        .upd         (cam_upd),
        .upd_idx     (idx_reg),
        .upd_key     (key_reg),
        .hit         (hit),
        .hit_idx     (hit_idx),
        .hit_running (hit_running),
        .free_any    (free_any),
        .free_idx    (free_idx)
    );

    assign rd_en   = (state_reg == S_LOOKUP);
    assign rd_addr = hit ? hit_idx : free_idx;
    assign wr_en   = upd_fire && found_reg;

    stst_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (REC_W),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_reg),
        .wdata (wr_rec),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign old_rec = fresh_reg ? stst_pkg::STAT_RESET : stst_pkg::stat_rec_t'(rd_data);

    stst_alu u_alu (
        .old_rec (old_rec),
        .elapsed (elapsed_reg),
        .new_rec (alu_rec)
    );

    always_comb
    begin
        wr_rec = old_rec;
        if (action_reg == stst_pkg::ACT_BEGIN)
        begin
            wr_rec.start = ts_reg;
        end
        else
        begin
            wr_rec = alu_rec;
        end
    end

    assign cam_upd.en      = wr_en;
    assign cam_upd.claim   = fresh_reg;
    assign cam_upd.running = (action_reg == stst_pkg::ACT_BEGIN);

    always_comb
    begin
        state_next       = state_reg;
        action_next      = action_reg;
        key_next         = key_reg;
        ts_next          = ts_reg;
        idx_next         = idx_reg;
        found_next       = found_reg;
        fresh_next       = fresh_reg;
        status_next      = status_reg;
        elapsed_next     = elapsed_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_elapsed_next = out_elapsed_reg;
        out_rec_next     = out_rec_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next = action;
                    key_next    = section_key[KEY_W-1:0];
                    ts_next     = timestamp;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                idx_next   = rd_addr;
                fresh_next = 1'b0;
                found_next = hit;
                if (action_reg == stst_pkg::ACT_BEGIN)
                begin
                    if (hit)
                    begin
                        status_next = hit_running ? stst_pkg::ST_BEGIN_RUNNING
                                                  : stst_pkg::ST_OK;
                    end
                    else if (free_any)
                    begin
                        status_next = stst_pkg::ST_OK;
                        found_next  = 1'b1;
                        fresh_next  = 1'b1;
                    end
                    else
                    begin
                        status_next = stst_pkg::ST_TABLE_FULL;
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        status_next = hit_running ? stst_pkg::ST_OK
                                                  : stst_pkg::ST_END_IDLE;
                    end
                    else
                    begin
                        status_next = stst_pkg::ST_END_NO_SLOT;
                    end
                end
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                if (action_reg == stst_pkg::ACT_END)
                begin
                    elapsed_next = {1'b0, ts_reg} - {1'b0, old_rec.start};
                end
                else
                begin
                    elapsed_next = '0;
                end
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (upd_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (found_reg)
                    begin
                        out_slot_next    = stst_pkg::SLOT_OUT_BITS'(idx_reg);
                        out_elapsed_next = elapsed_reg;
                        out_rec_next     = wr_rec;
                    end
                    else
                    begin
                        out_slot_next    = '0;
                        out_elapsed_next = '0;
                        out_rec_next     = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            action_reg      <= stst_pkg::ACT_BEGIN;
            key_reg         <= '0;
            ts_reg          <= '0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            fresh_reg       <= 1'b0;
            status_reg      <= stst_pkg::ST_OK;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= stst_pkg::ST_OK;
            out_slot_reg    <= '0;
            out_elapsed_reg <= '0;
            out_rec_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            action_reg      <= action_next;
            key_reg         <= key_next;
            ts_reg          <= ts_next;
            idx_reg         <= idx_next;
            found_reg       <= found_next;
            fresh_reg       <= fresh_next;
            status_reg      <= status_next;
            elapsed_reg     <= elapsed_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_slot_reg    <= out_slot_next;
            out_elapsed_reg <= out_elapsed_next;
            out_rec_reg     <= out_rec_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot_index    = out_slot_reg;
    assign elapsed_ticks = out_elapsed_reg;
    assign total_ticks   = out_rec_reg.total;
    assign min_ticks     = out_rec_reg.min;
    assign max_ticks     = out_rec_reg.max;
    assign call_count    = out_rec_reg.count;

endmodule

@@ sv/stst_cam.sv @@
// Key match array with used and running flags per slot.
module stst_cam #(
    parameter int SLOT_COUNT = stst_pkg::SLOT_COUNT_DEF,
    parameter int KEY_W      = stst_pkg::KEY_BITS_DEF,
    parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 lookup_en,
    input  logic [KEY_W-1:0]     lookup_key,
    input  stst_pkg::cam_upd_t   upd,
    input  logic [IDX_W-1:0]     upd_idx,
    input  logic [KEY_W-1:0]     upd_key,
    output logic                 hit,
    output logic [IDX_W-1:0]     hit_idx,
    output logic                 hit_running,
    output logic                 free_any,
    output logic [IDX_W-1:0]     free_idx
);

    logic [KEY_W-1:0]      key_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] used_reg;
    logic [SLOT_COUNT-1:0] running_reg;
    logic [SLOT_COUNT-1:0] match_reg;
    logic [SLOT_COUNT-1:0] free_reg;
    logic [SLOT_COUNT-1:0] match_next;

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            match_next[i] = used_reg[i] && (key_mem[i] == lookup_key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            running_reg <= '0;
            match_reg   <= '0;
            free_reg    <= '0;
        end
        else
        begin
            if (lookup_en)
            begin
                match_reg <= match_next;
                free_reg  <= ~used_reg;
            end
            if (upd.en)
            begin
                running_reg[upd_idx] <= upd.running;
                if (upd.claim)
                begin
                    used_reg[upd_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.en && upd.claim)
        begin
            key_mem[upd_idx] <= upd_key;
        end
    end

    // Keys of used slots are unique, so the match vector is at most one-hot.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit         = |match_reg;
    assign hit_running = |(match_reg & running_reg);
    assign free_any    = |free_reg;

endmodule

@@ sv/stst_ram.sv @@
// Single-port-write, single-port-read synchronous memory with registered read data.
module stst_ram #(
    parameter int DEPTH = stst_pkg::SLOT_COUNT_DEF,
    parameter int WIDTH = $bits(stst_pkg::stat_rec_t),
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/stst_alu.sv @@
// Statistics update for one finished run: saturating total, min, max and count.
module stst_alu (
    input  stst_pkg::stat_rec_t                 old_rec,
    input  logic [stst_pkg::TIME_BITS-1:0]      elapsed,
    output stst_pkg::stat_rec_t                 new_rec
);

    logic signed [stst_pkg::TIME_BITS:0] sum;

    assign sum = $signed({2'b00, old_rec.total}) + $signed({elapsed[stst_pkg::TIME_BITS-1], elapsed});

    always_comb
    begin
        new_rec = old_rec;
        if (sum[stst_pkg::TIME_BITS])
        begin
            new_rec.total = '0;
        end
        else if (sum[stst_pkg::TIME_BITS-1])
        begin
            new_rec.total = stst_pkg::TOTAL_MAX;
        end
        else
        begin
            new_rec.total = sum[stst_pkg::TS_BITS-1:0];
        end
        if ((old_rec.min == '1) || ($signed(elapsed) < $signed(old_rec.min)))
        begin
            new_rec.min = elapsed;
        end
        if ($signed(elapsed) > $signed(old_rec.max))
        begin
            new_rec.max = elapsed;
        end
        if (old_rec.count != stst_pkg::COUNT_MAX)
        begin
            new_rec.count = old_rec.count + 1'b1;
        end
    end

endmodule

@@ dv/tb_section_timing_stats_table_core.sv @@
// Self-checking testbench for section_timing_stats_table_core with a queue-fed driver.
module tb_section_timing_stats_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import stst_pkg::*;

    localparam int SLOTS          = SLOT_COUNT_DEF;
    localparam int KEY_POOL       = 48;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int END_SETTLE     = 20;

    typedef struct {
        logic                     act;
        logic [KEY_PORT_BITS-1:0] key;
        logic [TS_BITS-1:0]       ts;
    } section_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]   status;
        logic [SLOT_OUT_BITS-1:0] slot;
        logic [TIME_BITS-1:0]     elapsed;
        logic [TS_BITS-1:0]       total;
        logic [TIME_BITS-1:0]     shortest;
        logic [TIME_BITS-1:0]     longest;
        logic [COUNT_BITS-1:0]    count;
    } stat_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic                              action = ACT_BEGIN;
    logic [KEY_PORT_BITS-1:0]          section_key = '0;
    logic [TS_BITS-1:0]                timestamp = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [STATUS_BITS-1:0]            status;
    logic [SLOT_OUT_BITS-1:0]          slot_index;
    logic signed [TIME_BITS-1:0]       elapsed_ticks;
    logic [TS_BITS-1:0]                total_ticks;
    logic signed [TIME_BITS-1:0]       min_ticks;
    logic signed [TIME_BITS-1:0]       max_ticks;
    logic [COUNT_BITS-1:0]             call_count;

    logic                              tbl_used [SLOTS];
    logic [KEY_PORT_BITS-1:0]          tbl_key [SLOTS];
    logic                              tbl_running [SLOTS];
    logic [TS_BITS-1:0]                tbl_start [SLOTS];
    logic [TS_BITS-1:0]                tbl_total [SLOTS];
    logic signed [TIME_BITS-1:0]       tbl_min [SLOTS];
    logic signed [TIME_BITS-1:0]       tbl_max [SLOTS];
    logic [COUNT_BITS-1:0]             tbl_count [SLOTS];

    section_item_t                     section_backlog[$];
    stat_result_t                      pending_stats[$];
    logic [KEY_PORT_BITS-1:0]          key_pool [KEY_POOL];
    bit                                pool_open [KEY_POOL];
    logic [TS_BITS-1:0]                sim_clock = '0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_block = 1'b0;
    int accepted_items = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    section_timing_stats_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .section_key   (section_key),
        .timestamp     (timestamp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .slot_index    (slot_index),
        .elapsed_ticks (elapsed_ticks),
        .total_ticks   (total_ticks),
        .min_ticks     (min_ticks),
        .max_ticks     (max_ticks),
        .call_count    (call_count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic stat_result_t apply_section_event(
        input logic                     act,
        input logic [KEY_PORT_BITS-1:0] key,
        input logic [TS_BITS-1:0]       ts
    );
        stat_result_t                r;
        int                          s;
        logic [TIME_BITS-1:0]        diff;
        logic [TIME_BITS-1:0]        sum;
        logic [TIME_BITS-1:0]        mag;
        logic signed [TIME_BITS-1:0] run_ticks;
        r = '0;
        r.status = ST_OK;
        run_ticks = '0;
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (s < 0 && tbl_used[i] && tbl_key[i] == key)
                s = i;
        if (act == ACT_BEGIN)
        begin
            if (s >= 0)
            begin
                if (tbl_running[s])
                    r.status = ST_BEGIN_RUNNING;
            end
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && !tbl_used[i])
                        s = i;
                if (s >= 0)
                begin
                    tbl_used[s] = 1'b1;
                    tbl_key[s] = key;
                end
                else
                    r.status = ST_TABLE_FULL;
            end
            if (s >= 0)
            begin
                tbl_running[s] = 1'b1;
                tbl_start[s] = ts;
            end
        end
        else if (s < 0)
            r.status = ST_END_NO_SLOT;
        else
        begin
            if (!tbl_running[s])
                r.status = ST_END_IDLE;
            diff = {1'b0, ts} - {1'b0, tbl_start[s]};
            run_ticks = signed'(diff);
            tbl_running[s] = 1'b0;
            if (!diff[TIME_BITS-1])
            begin
                sum = {1'b0, tbl_total[s]} + diff;
                tbl_total[s] = sum[TIME_BITS-1] ? TOTAL_MAX : sum[TS_BITS-1:0];
            end
            else
            begin
                mag = -diff;
                tbl_total[s] = (mag > {1'b0, tbl_total[s]}) ? '0
                                                             : tbl_total[s] - mag[TS_BITS-1:0];
            end
            if (tbl_min[s] == '1 || run_ticks < tbl_min[s])
                tbl_min[s] = run_ticks;
            if (run_ticks > tbl_max[s])
                tbl_max[s] = run_ticks;
            if (tbl_count[s] != COUNT_MAX)
                tbl_count[s] = tbl_count[s] + 1'b1;
        end
        if (s >= 0)
        begin
            r.slot = s[SLOT_OUT_BITS-1:0];
            r.elapsed = run_ticks;
            r.total = tbl_total[s];
            r.shortest = tbl_min[s];
            r.longest = tbl_max[s];
            r.count = tbl_count[s];
        end
        return r;
    endfunction

    function automatic void queue_item(
        input logic                     act,
        input logic [KEY_PORT_BITS-1:0] key,
        input logic [TS_BITS-1:0]       ts
    );
        section_item_t it;
        it.act = act;
        it.key = key;
        it.ts = ts;
        section_backlog = {section_backlog, it};
    endfunction

    // Mostly matched begin/end pairs on pooled keys; the rest is noise.
    function automatic void queue_random_item();
        int            p;
        int            roll;
        section_item_t it;
        p = $urandom_range(KEY_POOL-1);
        roll = $urandom_range(99);
        if ($urandom_range(3) == 0)
            sim_clock = sim_clock + 63'($urandom);
        else
            sim_clock = sim_clock + 63'($urandom_range(500, 1));
        if (roll < 80)
        begin
            it.act = pool_open[p] ? ACT_END : ACT_BEGIN;
            pool_open[p] = !pool_open[p];
            it.key = key_pool[p];
            it.ts = sim_clock;
        end
        else
        begin
            it.act = 1'($urandom_range(1));
            it.key = ($urandom_range(1) != 0) ? KEY_PORT_BITS'($urandom) : key_pool[p];
            case ($urandom_range(3))
                0: it.ts = '0;
                1: it.ts = TOTAL_MAX;
                2: it.ts = TS_BITS'({$urandom, $urandom});
                default: it.ts = sim_clock - 63'($urandom_range(1000));
            endcase
        end
        section_backlog = {section_backlog, it};
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(
        input string                name,
        input logic [TIME_BITS-1:0] got,
        input logic [TIME_BITS-1:0] want
    );
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_items
        section_item_t nxt_item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_BEGIN;
            section_key <= '0;
            timestamp <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_stats = {pending_stats,
                                 apply_section_event(action, section_key, timestamp)};
                accepted_items++;
            end
            if (!in_valid || in_ready)
            begin
                if (section_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt_item = section_backlog.pop_front();
                    in_valid <= 1'b1;
                    action <= nxt_item.act;
                    section_key <= nxt_item.key;
                    timestamp <= nxt_item.ts;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        stat_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_stats.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              results_seen));
                else
                begin
                    want = pending_stats.pop_front();
                    check_field("status", 64'(status), 64'(want.status));
                    check_field("slot_index", 64'(slot_index), 64'(want.slot));
                    check_field("elapsed_ticks", elapsed_ticks, want.elapsed);
                    check_field("total_ticks", 64'(total_ticks), 64'(want.total));
                    check_field("min_ticks", min_ticks, want.shortest);
                    check_field("max_ticks", max_ticks, want.longest);
                    check_field("call_count", 64'(call_count), 64'(want.count));
                end
            end
            out_ready <= !rx_block && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Hold off the receiver long enough to back the block up into its input.
    initial
    begin
        while (accepted_items < 60)
            @(negedge clk);
        rx_block = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        rx_block = 1'b0;
    end

    initial
    begin
        int idle_plan [4];
        int stall_plan [4];
        idle_plan = '{0, 63, 0, 19};
        stall_plan = '{0, 0, 63, 19};
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_running[i] = 1'b0;
            tbl_start[i] = '0;
            tbl_total[i] = '0;
            tbl_min[i] = '1;
            tbl_max[i] = '0;
            tbl_count[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = KEY_PORT_BITS'($urandom);
        foreach (pool_open[i])
            pool_open[i] = 1'b0;
        pool_open[1] = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_item(ACT_BEGIN, 32'h0000_0000, 63'd0);
        queue_item(ACT_END, 32'h0000_0000, 63'd100);
        queue_item(ACT_END, 32'h0000_0000, 63'd250);
        queue_item(ACT_BEGIN, 32'hFFFF_FFFF, TOTAL_MAX);
        queue_item(ACT_BEGIN, 32'hFFFF_FFFF, 63'd10);
        queue_item(ACT_END, 32'hFFFF_FFFF, TOTAL_MAX);
        queue_item(ACT_BEGIN, 32'hFFFF_FFFF, 63'd0);
        queue_item(ACT_END, 32'hFFFF_FFFF, TOTAL_MAX);
        queue_item(ACT_BEGIN, 32'h0000_0000, TOTAL_MAX);
        queue_item(ACT_END, 32'h0000_0000, 63'd0);
        queue_item(ACT_END, 32'h1234_5678, 63'd5);
        queue_item(ACT_BEGIN, 32'hA5A5_A5A5, 63'h2AAA_AAAA_AAAA_AAAA);
        queue_item(ACT_END, 32'hA5A5_A5A5, 63'h2AAA_AAAA_AAAA_AAAA);
        queue_item(ACT_BEGIN, 32'h5A5A_5A5A, 63'h2AAA_AAAA_AAAA_AAAA);
        queue_item(ACT_END, 32'h5A5A_5A5A, 63'h5555_5555_5555_5555);
        queue_item(ACT_BEGIN, 32'h5A5A_5A5A, 63'h5555_5555_5555_5555);
        queue_item(ACT_END, 32'h5A5A_5A5A, 63'h0000_0000_0000_0001);
        queue_item(ACT_BEGIN, 32'hFFFF_FFFF, 63'd1000);

        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct = idle_plan[ph];
            rx_stall_pct = stall_plan[ph];
            repeat (ITEMS_PER_PHASE) queue_random_item();
            // drain completely before the next phase
            while (section_backlog.size() != 0 || in_valid || pending_stats.size() != 0)
                @(negedge clk);
        end

        repeat (END_SETTLE) @(negedge clk);
        if (pending_stats.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_stats.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
